>>> rtl/core/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    localparam int unsigned OPCODE_W   = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LIMIT_W    = 16;
    localparam int unsigned STEP_W     = 2;
    localparam int unsigned HOLD_W     = 2;
    localparam int unsigned BIT_IDX_W  = 4;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [LIMIT_W-1:0]    ACK_LIMIT_RESET = 16'd60000;
    localparam logic [BIT_IDX_W-1:0]  BITS_PER_BYTE   = 4'd8;
    localparam logic [APB_ADDR_W-1:0] ADDR_ACK_LIMIT  = 3'd0;

    // Opcode zero is both the tick item and the idle command.
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_WRITE   = 3'd3,
        OP_READ    = 3'd4,
        OP_ACK     = 3'd5,
        OP_NOACK   = 3'd6,
        OP_WAITACK = 3'd7
    } t_opcode;

    typedef struct packed {
        t_opcode                cmd;
        logic [STEP_W-1:0]      step;
        logic [HOLD_W-1:0]      hold;
        logic [BIT_IDX_W-1:0]   bit_idx;
        logic [BYTE_W-1:0]      shift_byte;
        logic [LIMIT_W-1:0]     wait_count;
        logic                   scl;
        logic                   sda;
        logic                   ack;
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/i2cm_ifs.sv
`default_nettype none

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] write_byte;
    logic       sda_sample;

    modport source (output valid, output opcode, output write_byte, output sda_sample,
                    input ready);
    modport sink   (input valid, input opcode, input write_byte, input sda_sample,
                    output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       cmd_done;
    logic [7:0] read_data;
    logic       ack_seen;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output cmd_done, output read_data, output ack_seen, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                    input cmd_done, input read_data, input ack_seen, output ready);
endinterface

`default_nettype wire

>>> rtl/core/i2cm_step.sv
`default_nettype none

module i2cm_step (
    input  var i2cm_pkg::t_state                   i_state,
    input  var logic [i2cm_pkg::OPCODE_W-1:0]      i_opcode,
    input  var logic [i2cm_pkg::BYTE_W-1:0]        i_write_byte,
    input  var logic                               i_sda_sample,
    input  var logic [i2cm_pkg::LIMIT_W-1:0]       i_ack_limit,
    output i2cm_pkg::t_state                       o_state,
    output logic                                   o_cmd_done
);
    import i2cm_pkg::*;

    t_opcode              w_op;
    logic [BIT_IDX_W-1:0] w_bit_next;

    assign w_op       = t_opcode'(i_opcode);
    assign w_bit_next = i_state.bit_idx + 4'd1;

    always_comb begin
        o_state    = i_state;
        o_cmd_done = 1'b0;

        if (w_op != OP_TICK && i_state.cmd == OP_TICK) begin
            // New command: drive its first line levels, or load the byte for a write.
            o_state.cmd     = w_op;
            o_state.bit_idx = '0;
            o_state.step    = 2'd0;
            o_state.hold    = 2'd1;
            case (w_op)
                OP_START: begin
                    o_state.sda = 1'b1;
                    o_state.scl = 1'b1;
                end
                OP_STOP: begin
                    o_state.scl = 1'b0;
                    o_state.sda = 1'b0;
                end
                OP_WRITE: begin
                    o_state.wait_count = {8'd0, i_write_byte};
                end
                OP_READ: begin
                    o_state.sda = 1'b1;
                end
                OP_ACK, OP_NOACK: begin
                    o_state.scl = 1'b0;
                end
                default: begin
                    o_state.scl        = 1'b0;
                    o_state.sda        = 1'b1;
                    o_state.wait_count = '0;
                end
            endcase
        end else if (i_state.cmd == OP_TICK) begin
            // Idle tick: hold everything.
        end else if (i_state.cmd == OP_WAITACK && i_state.step == 2'd1) begin
            if (i_sda_sample && i_state.wait_count < i_ack_limit) begin
                o_state.wait_count = i_state.wait_count + 16'd1;
            end else begin
                o_state.ack  = ~i_sda_sample;
                o_state.scl  = 1'b0;
                o_state.step = 2'd2;
                o_state.hold = 2'd1;
            end
        end else if (i_state.hold > 2'd1) begin
            o_state.hold = i_state.hold - 2'd1;
        end else begin
            o_state.hold = 2'd0;
            o_cmd_done   = 1'b1;
            case (i_state.cmd)
                OP_START: begin
                    if (i_state.step == 2'd0) begin
                        o_state.sda = 1'b0;
                        o_state.step = 2'd1; o_state.hold = 2'd1; o_cmd_done = 1'b0;
                    end else if (i_state.step == 2'd1) begin
                        o_state.scl = 1'b0;
                        o_state.step = 2'd2; o_state.hold = 2'd2; o_cmd_done = 1'b0;
                    end
                end
                OP_STOP: begin
                    if (i_state.step == 2'd0) begin
                        o_state.scl = 1'b1;
                        o_state.step = 2'd1; o_state.hold = 2'd1; o_cmd_done = 1'b0;
                    end else if (i_state.step == 2'd1) begin
                        o_state.sda = 1'b1;
                        o_state.step = 2'd2; o_state.hold = 2'd2; o_cmd_done = 1'b0;
                    end
                end
                OP_WRITE: begin
                    // Low byte of wait_count is the transmit shifter, MSB first.
                    if (i_state.step == 2'd0) begin
                        o_state.sda        = i_state.wait_count[7];
                        o_state.wait_count = {8'd0, i_state.wait_count[6:0], 1'b0};
                        o_state.step = 2'd1; o_state.hold = 2'd1; o_cmd_done = 1'b0;
                    end else if (i_state.step == 2'd1) begin
                        o_state.scl = 1'b1;
                        o_state.step = 2'd2; o_state.hold = 2'd1; o_cmd_done = 1'b0;
                    end else if (i_state.step == 2'd2) begin
                        o_state.scl     = 1'b0;
                        o_state.bit_idx = w_bit_next;
                        o_cmd_done      = 1'b0;
                        if (w_bit_next < BITS_PER_BYTE) begin
                            o_state.step = 2'd0; o_state.hold = 2'd1;
                        end else begin
                            o_state.step = 2'd3; o_state.hold = 2'd2;
                        end
                    end
                end
                OP_READ: begin
                    if (i_state.step == 2'd0) begin
                        o_state.scl = 1'b0;
                        o_state.step = 2'd1; o_state.hold = 2'd2; o_cmd_done = 1'b0;
                    end else if (i_state.step == 2'd1) begin
                        o_state.scl = 1'b1;
                        o_state.step = 2'd2; o_state.hold = 2'd1; o_cmd_done = 1'b0;
                    end else begin
                        o_state.shift_byte = {i_state.shift_byte[6:0], i_sda_sample};
                        o_state.bit_idx    = w_bit_next;
                        if (w_bit_next < BITS_PER_BYTE) begin
                            o_state.scl = 1'b0;
                            o_state.step = 2'd1; o_state.hold = 2'd2; o_cmd_done = 1'b0;
                        end
                    end
                end
                OP_ACK, OP_NOACK: begin
                    if (i_state.step == 2'd0) begin
                        o_state.sda = (i_state.cmd == OP_NOACK);
                        o_state.step = 2'd1; o_state.hold = 2'd1; o_cmd_done = 1'b0;
                    end else if (i_state.step == 2'd1) begin
                        o_state.scl = 1'b1;
                        o_state.step = 2'd2; o_state.hold = 2'd1; o_cmd_done = 1'b0;
                    end else if (i_state.step == 2'd2) begin
                        o_state.scl  = 1'b0;
                        o_state.step = 2'd3;
                        o_state.hold = (i_state.cmd == OP_NOACK) ? 2'd1 : 2'd2;
                        o_cmd_done   = 1'b0;
                    end
                end
                OP_WAITACK: begin
                    if (i_state.step == 2'd0) begin
                        o_state.scl = 1'b1;
                        o_state.step = 2'd1; o_state.hold = 2'd0; o_cmd_done = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            if (o_cmd_done) begin
                o_state.cmd  = OP_TICK;
                o_state.step = 2'd0;
                o_state.hold = 2'd0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/i2c_master_bit_engine_core.sv
`default_nettype none

// Channel   Dir  Handshake     Payload
// i_cmd     in   valid/ready   opcode[2:0], write_byte[7:0], sda_sample
// o_res     out  valid/ready   scl_level, sda_level, busy_res, cmd_done,
//                              read_data[7:0], ack_seen
// APB       in   psel/penable  ack_timeout_limit at byte address 0 (16 bits)
//
// One item per cycle while the result is not stalled: the state update is a
// single pass of logic from the state registers into the state and result
// registers. A new item is taken while the result register is empty or being
// drained. Reset is synchronous, active low; it leaves both lines released and
// the limit at 60000. A stalled result holds the input side; nothing is dropped.

module i2c_master_bit_engine_core (
    input  var logic                                 i_clk,
    input  var logic                                 i_rst_n,
    i2cm_cmd_if.sink                                 i_cmd,
    i2cm_res_if.source                               o_res,
    input  var logic                                 psel,
    input  var logic                                 penable,
    input  var logic                                 pwrite,
    input  var logic [i2cm_pkg::APB_ADDR_W-1:0]      paddr,
    input  var logic [i2cm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [i2cm_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    import i2cm_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic                 w_done;
    logic [LIMIT_W-1:0]   r_ack_limit;
    logic                 r_valid;
    logic                 r_scl;
    logic                 r_sda;
    logic                 r_busy;
    logic                 r_done;
    logic [BYTE_W-1:0]    r_read_data;
    logic                 r_ack;
    logic                 w_accept;
    logic                 w_cfg_wr;
    logic                 w_sel_limit;

    assign pready      = 1'b1;
    assign w_sel_limit = (paddr[APB_ADDR_W-1:2] == ADDR_ACK_LIMIT[APB_ADDR_W-1:2]);
    assign w_cfg_wr    = psel & penable & pwrite & w_sel_limit;
    assign prdata      = w_sel_limit ? {{(APB_DATA_W-LIMIT_W){1'b0}}, r_ack_limit} : '0;

    assign i_cmd.ready = ~r_valid | o_res.ready;
    assign w_accept    = i_cmd.valid & i_cmd.ready;

    i2cm_step u_step (
        .i_state      (r_state),
        .i_opcode     (i_cmd.opcode),
        .i_write_byte (i_cmd.write_byte),
        .i_sda_sample (i_cmd.sda_sample),
        .i_ack_limit  (r_ack_limit),
        .o_state      (n_state),
        .o_cmd_done   (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_limit <= ACK_LIMIT_RESET;
        end else if (w_cfg_wr) begin
            r_ack_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{cmd: OP_TICK, step: '0, hold: '0, bit_idx: '0, shift_byte: '0,
                         wait_count: '0, scl: 1'b1, sda: 1'b1, ack: 1'b0};
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload: the state after the item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scl       <= n_state.scl;
            r_sda       <= n_state.sda;
            r_busy      <= (n_state.cmd != OP_TICK);
            r_done      <= w_done;
            r_read_data <= n_state.shift_byte;
            r_ack       <= n_state.ack;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.scl_level = r_scl;
    assign o_res.sda_level = r_sda;
    assign o_res.busy_res  = r_busy;
    assign o_res.cmd_done  = r_done;
    assign o_res.read_data = r_read_data;
    assign o_res.ack_seen  = r_ack;

endmodule

`default_nettype wire
